>>> hdl/blended_gain_angle_pd_core_defines.svh
// ----------------------------------------------------------------------------
// Blended gain angle PD core - assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLENDED_GAIN_ANGLE_PD_CORE_DEFINES_SVH
`define BLENDED_GAIN_ANGLE_PD_CORE_DEFINES_SVH

// same-cycle implication
`define BGAPD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGAPD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bgapd_pkg.sv
// ----------------------------------------------------------------------------
// bgapd_pkg
// Shared widths, register indexes and interface structs of the PD core.
// ----------------------------------------------------------------------------
`default_nettype none

package bgapd_pkg;

  localparam int ERR_W   = 16;             // Q3.12 error
  localparam int GAIN_W  = 16;             // Q8.8 gains, Q4.12 time factor
  localparam int W_W     = ERR_W + 1;      // weights and error difference
  localparam int DRIVE_W = 24;             // Q11.12 output
  localparam int CFG_IDX_W = 3;

  // digit-serial multiplier geometry
  localparam int DIG_W   = 4;
  localparam int NUM_DIG = 5;
  localparam int MB_W    = DIG_W * NUM_DIG;  // multiplier operand
  localparam int MA_W    = 40;               // multiplicand operand
  localparam int PROD_W  = 56;               // product / running sum

  localparam int D_SHIFT   = 12;
  localparam int RND_SHIFT = 20;
  localparam int Q_W       = PROD_W - RND_SHIFT;
  localparam int LIM_W     = GAIN_W + 1 + 4;

  localparam logic signed [W_W-1:0]    ONE_Q12  = W_W'(4096);
  localparam logic        [PROD_W-1:0] RND_BIAS = PROD_W'(1) << (RND_SHIFT - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P_SMALL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D_SMALL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_LARGE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D_LARGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_T_SCALE = 3'd4;

  localparam logic [GAIN_W-1:0] RST_P_SMALL = 16'd2560;
  localparam logic [GAIN_W-1:0] RST_D_SMALL = 16'd768;
  localparam logic [GAIN_W-1:0] RST_P_LARGE = 16'd1280;
  localparam logic [GAIN_W-1:0] RST_D_LARGE = 16'd0;
  localparam logic [GAIN_W-1:0] RST_T_SCALE = 16'd4096;

  typedef struct packed {
    logic [GAIN_W-1:0] p_small;
    logic [GAIN_W-1:0] d_small;
    logic [GAIN_W-1:0] p_large;
    logic [GAIN_W-1:0] d_large;
    logic [GAIN_W-1:0] t_scale;
  } gains_t;

  typedef struct packed {
    logic                     start;
    logic signed [MA_W-1:0]   a;
    logic signed [MB_W-1:0]   b;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [PROD_W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic                      valid;
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/bgapd_mul.sv
// ----------------------------------------------------------------------------
// bgapd_mul
// Digit-serial signed multiplier: the multiplier operand shifts out one
// 4-bit digit per cycle, MSB digit first (signed), Horner accumulation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blended_gain_angle_pd_core_defines.svh"

module bgapd_mul
  import bgapd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire mul_req_t req,
  output mul_rsp_t      rsp
);

  localparam int CNT_W = $clog2(NUM_DIG + 1);

  logic signed [MA_W-1:0]    a_r;
  logic        [MB_W-1:0]    b_r;
  logic signed [PROD_W-1:0]  acc_r;
  logic signed [PROD_W-1:0]  acc_nxt;
  logic        [CNT_W-1:0]   cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic        [DIG_W-1:0]   digit;
  logic                      top_dig;
  logic signed [DIG_W:0]     dig_s;
  logic signed [MA_W+DIG_W:0] part;

  assign digit   = b_r[MB_W-1 -: DIG_W];
  assign top_dig = (cnt_r == CNT_W'(NUM_DIG));
  // only the leading digit carries the sign
  assign dig_s   = {top_dig & digit[DIG_W-1], digit};
  assign part    = a_r * dig_s;
  assign acc_nxt = (acc_r <<< DIG_W) + PROD_W'(part);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_DIG);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= b_r << DIG_W;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

  `BGAPD_ASSERT_IMP(a_no_restart, req.start, !busy_r && !done_r, "multiply started while busy")

endmodule

`default_nettype wire

>>> hdl/bgapd_seq.sv
// ----------------------------------------------------------------------------
// bgapd_seq
// Sequencer for one transaction: weights, nine serial products, rounding
// to Q12 and symmetric clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module bgapd_seq
  import bgapd_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [ERR_W-1:0]  err,
  input  wire logic signed [ERR_W-1:0]  prev,
  input  wire gains_t                   gains,
  input  wire logic                     res_take,
  output logic                          idle,
  output res_t                          res,
  output mul_req_t                      mul_req,
  input  wire mul_rsp_t                 mul_rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_RND   = 3'd3;
  localparam logic [2:0] S_CLAMP = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // product steps
  localparam logic [3:0] ST_PW_S = 4'd0;  // w_small * kp_small
  localparam logic [3:0] ST_PW_L = 4'd1;  // + w_large * kp_large
  localparam logic [3:0] ST_P    = 4'd2;  // * e
  localparam logic [3:0] ST_DK_S = 4'd3;  // diff * kd_small
  localparam logic [3:0] ST_DW_S = 4'd4;  // * w_small, floor >> 12
  localparam logic [3:0] ST_DT_S = 4'd5;  // * T, accumulate
  localparam logic [3:0] ST_DK_L = 4'd6;
  localparam logic [3:0] ST_DW_L = 4'd7;
  localparam logic [3:0] ST_DT_L = 4'd8;

  logic [2:0]                state_r, state_nxt;
  logic [3:0]                step_r, step_nxt;
  logic signed [ERR_W-1:0]   e_r;
  logic signed [W_W-1:0]     ws_r, wl_r, diff_r;
  logic signed [MA_W-1:0]    tmp_r, tmp_nxt;
  logic signed [PROD_W-1:0]  total_r, total_nxt;
  logic signed [Q_W-1:0]     q12_r;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic                      clamped_r, clamped_nxt;

  logic signed [W_W-1:0]     e_ext, mag, diff_nxt;
  logic        [PROD_W-1:0]  rnd;
  logic        [GAIN_W:0]    lim_sum;
  logic signed [Q_W-1:0]     lim_q;
  logic signed [Q_W-1:0]     neg_lim_q;

  assign e_ext    = W_W'(err);
  assign mag      = err[ERR_W-1] ? -e_ext : e_ext;
  assign diff_nxt = e_ext - W_W'(prev);

  assign rnd       = total_r + RND_BIAS;
  assign lim_sum   = {1'b0, gains.p_small} + {1'b0, gains.p_large};
  assign lim_q     = $signed(Q_W'({lim_sum, 4'b0000}));
  assign neg_lim_q = -lim_q;

  // operand selection for the multiplier
  always_comb begin
    mul_req.start = (state_r == S_ISSUE);
    case (step_r)
      ST_PW_S: begin
        mul_req.a = MA_W'(ws_r);
        mul_req.b = MB_W'(gains.p_small);
      end
      ST_PW_L: begin
        mul_req.a = MA_W'(wl_r);
        mul_req.b = MB_W'(gains.p_large);
      end
      ST_P: begin
        mul_req.a = tmp_r;
        mul_req.b = MB_W'(e_r);
      end
      ST_DK_S: begin
        mul_req.a = MA_W'(diff_r);
        mul_req.b = MB_W'(gains.d_small);
      end
      ST_DW_S: begin
        mul_req.a = tmp_r;
        mul_req.b = MB_W'(ws_r);
      end
      ST_DK_L: begin
        mul_req.a = MA_W'(diff_r);
        mul_req.b = MB_W'(gains.d_large);
      end
      ST_DW_L: begin
        mul_req.a = tmp_r;
        mul_req.b = MB_W'(wl_r);
      end
      ST_DT_S, ST_DT_L: begin
        mul_req.a = tmp_r;
        mul_req.b = MB_W'(gains.t_scale);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    tmp_nxt     = tmp_r;
    total_nxt   = total_r;
    drive_nxt   = drive_r;
    clamped_nxt = clamped_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          step_nxt  = ST_PW_S;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mul_rsp.done) begin
          case (step_r)
            ST_PW_L:          tmp_nxt   = tmp_r + $signed(mul_rsp.p[MA_W-1:0]);
            ST_P:             total_nxt = mul_rsp.p;
            ST_DW_S, ST_DW_L: tmp_nxt   = $signed(mul_rsp.p[MA_W+D_SHIFT-1:D_SHIFT]);
            ST_DT_S, ST_DT_L: total_nxt = total_r + mul_rsp.p;
            default:          tmp_nxt   = $signed(mul_rsp.p[MA_W-1:0]);
          endcase
          if (step_r == ST_DT_L) begin
            state_nxt = S_RND;
          end else begin
            step_nxt  = step_r + 4'd1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_RND: state_nxt = S_CLAMP;
      S_CLAMP: begin
        if (q12_r > lim_q) begin
          drive_nxt   = lim_q[DRIVE_W-1:0];
          clamped_nxt = 1'b1;
        end else if (q12_r < neg_lim_q) begin
          drive_nxt   = neg_lim_q[DRIVE_W-1:0];
          clamped_nxt = 1'b1;
        end else begin
          drive_nxt   = q12_r[DRIVE_W-1:0];
          clamped_nxt = 1'b0;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_PW_S;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      e_r    <= err;
      ws_r   <= ONE_Q12 - mag;
      wl_r   <= mag;
      diff_r <= diff_nxt;
    end
    if (state_r == S_RND) begin
      q12_r <= $signed(rnd[PROD_W-1:RND_SHIFT]);
    end
    tmp_r     <= tmp_nxt;
    total_r   <= total_nxt;
    drive_r   <= drive_nxt;
    clamped_r <= clamped_nxt;
  end

  assign idle        = (state_r == S_IDLE);
  assign res.valid   = (state_r == S_DONE);
  assign res.drive   = drive_r;
  assign res.clamped = clamped_r;

endmodule

`default_nettype wire

>>> hdl/blended_gain_angle_pd_core.sv
// ----------------------------------------------------------------------------
// blended_gain_angle_pd_core: blended-gain PD angle controller, one axis per transaction
// Each transaction runs nine 5-digit serial products, then round, clamp and the
// output register. A new transaction is accepted only while the sequencer is idle;
// rst_n loads default gains, zeroes errors.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blended_gain_angle_pd_core_defines.svh"

module blended_gain_angle_pd_core
  import bgapd_pkg::*;
#(
  parameter int NUM_AXES = 3
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_axis,
  input  wire logic signed [ERR_W-1:0]    in_angle_error,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [DRIVE_W-1:0]       out_drive,
  output logic                            out_clamped,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [GAIN_W-1:0]          cfg_wdata
);

  gains_t                    gains_r;
  logic signed [ERR_W-1:0]   prev_err_r [NUM_AXES];
  logic signed [ERR_W-1:0]   prev_rd;
  logic                      in_acc;
  logic                      seq_idle;
  res_t                      seq_res;
  logic                      res_take;
  mul_req_t                  mul_req;
  mul_rsp_t                  mul_rsp;

  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_clamped_r;
  logic signed [DRIVE_W-1:0] lim_chk;
  logic                      drive_in_lim;
  logic                      drive_at_lim;

  assign in_ready = seq_idle;
  assign in_acc   = in_valid && seq_idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r.p_small <= RST_P_SMALL;
      gains_r.d_small <= RST_D_SMALL;
      gains_r.p_large <= RST_P_LARGE;
      gains_r.d_large <= RST_D_LARGE;
      gains_r.t_scale <= RST_T_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_P_SMALL: gains_r.p_small <= cfg_wdata;
        REG_D_SMALL: gains_r.d_small <= cfg_wdata;
        REG_P_LARGE: gains_r.p_large <= cfg_wdata;
        REG_D_LARGE: gains_r.d_large <= cfg_wdata;
        REG_T_SCALE: gains_r.t_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-axis previous error; an out-of-range axis reads zero and writes nothing
  always_comb begin
    prev_rd = '0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (32'(in_axis) == i) prev_rd = prev_err_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) prev_err_r[i] <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        if (32'(in_axis) == i) prev_err_r[i] <= in_angle_error;
      end
    end
  end

  bgapd_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .err      (in_angle_error),
    .prev     (prev_rd),
    .gains    (gains_r),
    .res_take (res_take),
    .idle     (seq_idle),
    .res      (seq_res),
    .mul_req  (mul_req),
    .mul_rsp  (mul_rsp)
  );

  bgapd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // output register decouples the result from the sequencer
  assign res_take = seq_res.valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_drive_r   <= seq_res.drive;
      out_clamped_r <= seq_res.clamped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_clamped = out_clamped_r;

  assign lim_chk = $signed(DRIVE_W'({({1'b0, gains_r.p_small} + {1'b0, gains_r.p_large}),
                                     4'b0000}));
  assign drive_in_lim = (out_drive_r <= lim_chk) && (out_drive_r >= -lim_chk);
  assign drive_at_lim = (out_drive_r == lim_chk) || (out_drive_r == -lim_chk);

  `BGAPD_ASSERT_IMP(a_drive_in_range, out_valid_r, drive_in_lim, "drive beyond limit")
  `BGAPD_ASSERT_IMP(a_clamp_at_limit, out_valid_r && out_clamped_r, drive_at_lim, "clamp off limit")
  `BGAPD_ASSERT_NXT(a_accept_busy, in_acc, !seq_idle && !seq_res.valid, "idle after accept")

endmodule

`default_nettype wire
